// File: src/sepq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event priority queue package
// Field widths, request and status codes, and the controller interface types.
// ----------------------------------------------------------------------------
package sepq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int REQ_W      = 2;
  localparam int TIME_W     = 32;
  localparam int KIND_W     = 3;
  localparam int TASK_NUM_W = 16;
  localparam int ARRIVAL_W  = 32;
  localparam int BURST_W    = 32;
  localparam int PRIO_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int ENTRY_W    = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [TIME_W-1:0]     event_time;
    logic [KIND_W-1:0]     event_kind;
    logic [TASK_NUM_W-1:0] task_number;
    logic [ARRIVAL_W-1:0]  task_arrival;
    logic [BURST_W-1:0]    task_burst;
    logic [PRIO_W-1:0]     task_priority;
  } slot_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_LAST,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_SHIFT_DOWN,
    WR_NEW_NEXT,
    WR_NEW_ZERO,
    WR_SHIFT_UP
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic    load_item;
    logic    clr_head;
    logic    cap_head;
    logic    set_status;
    status_t status_code;
    idx_op_t idx_op;
    wr_op_t  wr_op;
    cnt_op_t cnt_op;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    req_t req;
    logic full;
    logic empty;
    logic idx_zero;
    logic idx_at_last;
    logic goes_after;
    logic out_busy;
  } ctrl_sts_t;

endpackage

// File: src/sorted_event_priority_queue_unit.sv
`timescale 1ns / 1ps
// A query, a dropped insert, a failed remove or an insert into an empty queue goes from
// decode straight to the result. An insert into a nonempty queue scans from the tail and
// moves each later slot down one place; a remove captures the head and moves every later
// slot up one place. Requests are taken one at a time: a new request is accepted only when
// the controller is idle. A finished result may wait while the next request is accepted.
// Reset clears the occupancy count and the handshake state; slot contents are not cleared.
// ----------------------------------------------------------------------------
// Sorted event priority queue unit
// Bounded event queue ordered by time, then kind, then newest insert first.
// ----------------------------------------------------------------------------
module sorted_event_priority_queue_unit #(
  parameter int QUEUE_DEPTH = sepq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sepq_pkg::REQ_W-1:0]        req_type,
  input  logic [sepq_pkg::TIME_W-1:0]       event_time,
  input  logic [sepq_pkg::KIND_W-1:0]       event_kind,
  input  logic [sepq_pkg::TASK_NUM_W-1:0]   task_number,
  input  logic [sepq_pkg::ARRIVAL_W-1:0]    task_arrival,
  input  logic [sepq_pkg::BURST_W-1:0]      task_burst,
  input  logic [sepq_pkg::PRIO_W-1:0]       task_priority,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sepq_pkg::STATUS_W-1:0]     status,
  output logic [sepq_pkg::TIME_W-1:0]       head_time,
  output logic [sepq_pkg::KIND_W-1:0]       head_kind,
  output logic [sepq_pkg::TASK_NUM_W-1:0]   head_task_number,
  output logic [sepq_pkg::ARRIVAL_W-1:0]    head_task_arrival,
  output logic [sepq_pkg::BURST_W-1:0]      head_task_burst,
  output logic [sepq_pkg::PRIO_W-1:0]       head_task_priority,
  output logic                              queue_empty,
  output logic [sepq_pkg::ENTRY_W-1:0]      entry_count
);

  import sepq_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  slot_t     in_slot;
  slot_t     out_slot;
  status_t   out_status;

  assign in_slot.event_time    = event_time;
  assign in_slot.event_kind    = event_kind;
  assign in_slot.task_number   = task_number;
  assign in_slot.task_arrival  = task_arrival;
  assign in_slot.task_burst    = task_burst;
  assign in_slot.task_priority = task_priority;

  sepq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  sepq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (req_t'(req_type)),
    .in_slot   (in_slot),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_status(out_status),
    .out_slot  (out_slot),
    .out_empty (queue_empty),
    .out_count (entry_count)
  );

  assign status             = out_status;
  assign head_time          = out_slot.event_time;
  assign head_kind          = out_slot.event_kind;
  assign head_task_number   = out_slot.task_number;
  assign head_task_arrival  = out_slot.task_arrival;
  assign head_task_burst    = out_slot.task_burst;
  assign head_task_priority = out_slot.task_priority;

endmodule

// File: src/sepq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sepq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/sepq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event priority queue datapath
// Slot memory, occupancy count, scan index, captured request and result
// register.
// ----------------------------------------------------------------------------
module sepq_datapath #(
  parameter int QUEUE_DEPTH = sepq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  sepq_pkg::ctrl_cmd_t         cmd,
  output sepq_pkg::ctrl_sts_t         sts,
  input  sepq_pkg::req_t              in_req,
  input  sepq_pkg::slot_t             in_slot,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sepq_pkg::status_t           out_status,
  output sepq_pkg::slot_t             out_slot,
  output logic                        out_empty,
  output logic [sepq_pkg::ENTRY_W-1:0] out_count
);

  import sepq_pkg::*;

  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_W = $bits(slot_t);

  req_t              req;
  slot_t             item;
  slot_t             head;
  status_t           res_status;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  idx_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  count_m1;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  slot_t             ram_wdata;
  slot_t             ram_rdata;
  logic [SLOT_W-1:0] ram_rdata_raw;

  sepq_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata_raw)
  );

  assign ram_rdata = slot_t'(ram_rdata_raw);
  assign count_m1  = count - 1'b1;

  always_comb begin
    ram_we    = 1'b1;
    ram_waddr = idx;
    ram_wdata = item;
    case (cmd.wr_op)
      WR_SHIFT_DOWN: begin
        ram_waddr = IDX_W'(idx + 1'b1);
        ram_wdata = ram_rdata;
      end
      WR_NEW_NEXT: begin
        ram_waddr = IDX_W'(idx + 1'b1);
      end
      WR_NEW_ZERO: begin
        ram_waddr = '0;
      end
      WR_SHIFT_UP: begin
        ram_waddr = IDX_W'(idx - 1'b1);
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd.idx_op)
      IDX_ZERO: idx_next = '0;
      IDX_LAST: idx_next = IDX_W'(count_m1);
      IDX_INC:  idx_next = IDX_W'(idx + 1'b1);
      IDX_DEC:  idx_next = IDX_W'(idx - 1'b1);
      default:  idx_next = idx;
    endcase
  end

  always_comb begin
    case (cmd.cnt_op)
      CNT_INC: count_next = CNT_W'(count + 1'b1);
      CNT_DEC: count_next = count_m1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.load_item) begin
      req  <= in_req;
      item <= in_slot;
    end
    if (cmd.clr_head) begin
      head <= '0;
    end else if (cmd.cap_head) begin
      head <= ram_rdata;
    end
    if (cmd.set_status) begin
      res_status <= cmd.status_code;
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_slot   <= head;
      out_empty  <= (count == '0);
      out_count  <= ENTRY_W'(count);
    end
  end

  always_comb begin
    sts.req         = req;
    sts.full        = (count >= CNT_W'(QUEUE_DEPTH));
    sts.empty       = (count == '0);
    sts.idx_zero    = (idx == '0);
    sts.idx_at_last = (CNT_W'(idx) == count_m1);
    sts.goes_after  = (ram_rdata.event_time > item.event_time) ||
                      ((ram_rdata.event_time == item.event_time) &&
                       (ram_rdata.event_kind <= item.event_kind));
    sts.out_busy    = out_valid && !out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("Occupancy count exceeds the queue depth.");

  a_inc_not_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_op == CNT_INC) |-> (count < CNT_W'(QUEUE_DEPTH)))
    else $error("Insert committed into a full queue.");

  a_dec_not_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_op == CNT_DEC) |-> (count != '0))
    else $error("Remove committed on an empty queue.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && !out_ready))
    else $error("Result register loaded while a result is still pending.");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_op == WR_SHIFT_DOWN) |-> (CNT_W'(idx) < count))
    else $error("Slot moved from outside the occupied range.");

endmodule

// File: src/sepq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event priority queue controller
// Sequences the insertion scan, the head removal shift and the result
// transfer.
// ----------------------------------------------------------------------------
module sepq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sepq_pkg::ctrl_sts_t sts,
  output sepq_pkg::ctrl_cmd_t cmd
);

  import sepq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_LAST,
    S_REM_RD,
    S_REM_HEAD,
    S_SHF_RD,
    S_SHF_WR,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE) && !rst;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.clr_head   = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status_code = ST_OK;
        case (sts.req)
          REQ_INSERT: begin
            if (sts.full) begin
              cmd.status_code = ST_FULL;
              state_next      = S_FINISH;
            end else if (sts.empty) begin
              cmd.wr_op  = WR_NEW_ZERO;
              cmd.cnt_op = CNT_INC;
              state_next = S_FINISH;
            end else begin
              cmd.idx_op = IDX_LAST;
              state_next = S_INS_RD;
            end
          end
          REQ_REMOVE: begin
            if (sts.empty) begin
              cmd.status_code = ST_EMPTY;
              state_next      = S_FINISH;
            end else begin
              cmd.idx_op = IDX_ZERO;
              state_next = S_REM_RD;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_INS_RD: begin
        state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (sts.goes_after) begin
          cmd.wr_op = WR_SHIFT_DOWN;
          if (sts.idx_zero) begin
            state_next = S_INS_LAST;
          end else begin
            cmd.idx_op = IDX_DEC;
            state_next = S_INS_RD;
          end
        end else begin
          cmd.wr_op  = WR_NEW_NEXT;
          cmd.cnt_op = CNT_INC;
          state_next = S_FINISH;
        end
      end
      S_INS_LAST: begin
        cmd.wr_op  = WR_NEW_ZERO;
        cmd.cnt_op = CNT_INC;
        state_next = S_FINISH;
      end
      S_REM_RD: begin
        state_next = S_REM_HEAD;
      end
      S_REM_HEAD: begin
        cmd.cap_head = 1'b1;
        if (sts.idx_at_last) begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_FINISH;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_SHF_RD;
        end
      end
      S_SHF_RD: begin
        state_next = S_SHF_WR;
      end
      S_SHF_WR: begin
        cmd.wr_op = WR_SHIFT_UP;
        if (sts.idx_at_last) begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_FINISH;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_SHF_RD;
        end
      end
      S_FINISH: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_DECODE))
    else $error("Accepted request was not decoded.");

  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("Request accepted while another is in progress.");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && !sts.out_busy) |-> cmd.load_out)
    else $error("Finished request did not load its result.");

endmodule

// File: tb/tb_sorted_event_priority_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted event priority queue unit testbench
// Drives insert, remove and query requests through the valid/ready input
// channel while a software image of the sorted queue predicts each result.
// A checker compares every output transfer, field by field, with the oldest
// prediction. Both channels idle in random bursts, and the receiver at one
// point holds off long enough for the unit to stall its input.
// ----------------------------------------------------------------------------
module tb_sorted_event_priority_queue_unit;
  import sepq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int LONG_HOLD = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_REPORTS = 60;

  typedef struct packed {
    status_t               code;
    slot_t                 head;
    logic                  empty;
    logic [ENTRY_W-1:0]    count;
  } outcome_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [REQ_W-1:0]      req_type = '0;
  logic [TIME_W-1:0]     event_time = '0;
  logic [KIND_W-1:0]     event_kind = '0;
  logic [TASK_NUM_W-1:0] task_number = '0;
  logic [ARRIVAL_W-1:0]  task_arrival = '0;
  logic [BURST_W-1:0]    task_burst = '0;
  logic [PRIO_W-1:0]     task_priority = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [TIME_W-1:0]     head_time;
  logic [KIND_W-1:0]     head_kind;
  logic [TASK_NUM_W-1:0] head_task_number;
  logic [ARRIVAL_W-1:0]  head_task_arrival;
  logic [BURST_W-1:0]    head_task_burst;
  logic [PRIO_W-1:0]     head_task_priority;
  logic                  queue_empty;
  logic [ENTRY_W-1:0]    entry_count;

  slot_t    mirror_slots [DEPTH];
  int       mirror_count = 0;
  outcome_t awaited_outcomes [$];
  int       errors = 0;
  int       reports = 0;
  bit       idle_on = 1'b1;
  bit       hold_pending = 1'b0;
  int       hold_left = 0;
  int       gap_left = 0;
  int       quiet_cycles = 0;

  sorted_event_priority_queue_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .event_time(event_time),
    .event_kind(event_kind),
    .task_number(task_number),
    .task_arrival(task_arrival),
    .task_burst(task_burst),
    .task_priority(task_priority),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .head_time(head_time),
    .head_kind(head_kind),
    .head_task_number(head_task_number),
    .head_task_arrival(head_task_arrival),
    .head_task_burst(head_task_burst),
    .head_task_priority(head_task_priority),
    .queue_empty(queue_empty),
    .entry_count(entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic outcome_t apply_request(input logic [REQ_W-1:0] req, input slot_t ev);
    outcome_t res;
    int pos;
    int i;
    res = '0;
    res.code = ST_OK;
    case (req)
      REQ_INSERT: begin
        if (mirror_count >= DEPTH) begin
          res.code = ST_FULL;
        end else begin
          pos = 0;
          while (pos < mirror_count &&
                 (mirror_slots[pos].event_time < ev.event_time ||
                  (mirror_slots[pos].event_time == ev.event_time &&
                   mirror_slots[pos].event_kind > ev.event_kind)))
            pos++;
          for (i = mirror_count; i > pos; i--)
            mirror_slots[i] = mirror_slots[i-1];
          mirror_slots[pos] = ev;
          mirror_count++;
        end
      end
      REQ_REMOVE: begin
        if (mirror_count == 0) begin
          res.code = ST_EMPTY;
        end else begin
          res.head = mirror_slots[0];
          for (i = 1; i < mirror_count; i++)
            mirror_slots[i-1] = mirror_slots[i];
          mirror_count--;
        end
      end
      default: ;
    endcase
    res.empty = (mirror_count == 0);
    res.count = mirror_count[ENTRY_W-1:0];
    return res;
  endfunction

  function automatic slot_t random_event();
    slot_t ev;
    case ($urandom_range(0, 5))
      0, 1: ev.event_time = $urandom_range(0, 7);
      2: ev.event_time = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      3: ev.event_time = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      default: ev.event_time = $urandom;
    endcase
    ev.event_kind = KIND_W'($urandom_range(0, 7));
    ev.task_number = TASK_NUM_W'($urandom);
    ev.task_arrival = $urandom;
    ev.task_burst = $urandom;
    ev.task_priority = PRIO_W'($urandom);
    return ev;
  endfunction

  function automatic slot_t make_event(input logic [TIME_W-1:0] t, input logic [KIND_W-1:0] k,
                                       input logic [TASK_NUM_W-1:0] num);
    slot_t ev;
    ev.event_time = t;
    ev.event_kind = k;
    ev.task_number = num;
    ev.task_arrival = ~t;
    ev.task_burst = {num, ~num};
    ev.task_priority = num[PRIO_W-1:0];
    return ev;
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] req, input slot_t ev);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    event_time <= ev.event_time;
    event_kind <= ev.event_kind;
    task_number <= ev.task_number;
    task_arrival <= ev.task_arrival;
    task_burst <= ev.task_burst;
    task_priority <= ev.task_priority;
    do @(posedge clk); while (!in_ready);
    awaited_outcomes.push_back(apply_request(req, ev));
  endtask

  task automatic release_and_drain();
    in_valid <= 1'b0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic test_special_codes();
    send_request(REQ_QUERY, random_event());
    send_request(REQ_REMOVE, random_event());
    send_request(REQ_UNUSED, random_event());
  endtask

  task automatic test_ordering();
    slot_t ev;
    ev = '1;
    ev.event_kind = 3'd0;
    send_request(REQ_INSERT, ev);
    send_request(REQ_INSERT, '0 | make_event(32'h0, 3'd7, 16'h0));
    send_request(REQ_INSERT, make_event(32'd5, 3'd3, 16'h1111));
    send_request(REQ_INSERT, make_event(32'd5, 3'd3, 16'h2222));
    send_request(REQ_INSERT, make_event(32'd5, 3'd7, 16'h3333));
    send_request(REQ_INSERT, make_event(32'd5, 3'd0, 16'h4444));
    send_request(REQ_INSERT, make_event(32'd0, 3'd0, 16'hFFFF));
    send_request(REQ_QUERY, random_event());
    repeat (8) send_request(REQ_REMOVE, random_event());
  endtask

  task automatic test_full_queue();
    while (mirror_count > 0) send_request(REQ_REMOVE, random_event());
    repeat (DEPTH) send_request(REQ_INSERT, random_event());
    repeat (2) send_request(REQ_INSERT, random_event());
    send_request(REQ_QUERY, random_event());
    repeat (DEPTH + 1) send_request(REQ_REMOVE, random_event());
  endtask

  task automatic test_random_mix(input int n_items);
    int sent;
    int phase_len;
    int insert_pct;
    int pick;
    logic [REQ_W-1:0] req;
    sent = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(10, 60);
      case ($urandom_range(0, 2))
        0: insert_pct = 80;
        1: insert_pct = 20;
        default: insert_pct = 50;
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)
          req = $urandom_range(0, 1) ? REQ_QUERY : REQ_UNUSED;
        else if (pick < 4 + insert_pct * 96 / 100)
          req = REQ_INSERT;
        else
          req = REQ_REMOVE;
        send_request(req, random_event());
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_pending = 1'b1;
    repeat (40)
      send_request($urandom_range(0, 9) < 7 ? REQ_INSERT : REQ_REMOVE, random_event());
    release_and_drain();
  endtask

  task automatic test_streaming(input int n_items);
    idle_on = 1'b0;
    repeat (n_items)
      send_request($urandom_range(0, 1) ? REQ_INSERT : REQ_REMOVE, random_event());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result transfer expected none actual status %0h count %0d",
                 $time, status, entry_count);
      end else begin
        want = awaited_outcomes.pop_front();
        check_field("status", want.code, status);
        check_field("head_time", want.head.event_time, head_time);
        check_field("head_kind", want.head.event_kind, head_kind);
        check_field("head_task_number", want.head.task_number, head_task_number);
        check_field("head_task_arrival", want.head.task_arrival, head_task_arrival);
        check_field("head_task_burst", want.head.task_burst, head_task_burst);
        check_field("head_task_priority", want.head.task_priority, head_task_priority);
        check_field("queue_empty", want.empty, queue_empty);
        check_field("entry_count", want.count, entry_count);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_codes();
    test_ordering();
    test_full_queue();
    test_random_mix(800);
    test_backpressure();
    test_streaming(150);
    release_and_drain();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
